>>> rtl/core/nwt_pkg.sv
// ----------------------------------------------------------------------------
// nwt_pkg
// Shared types and constants for the number to word tokens block.
// ----------------------------------------------------------------------------
package nwt_pkg;

	localparam int BIN_W      = 31;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CNT_W      = 5;
	localparam int TOK_W      = 5;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BIN_W - 1);

	localparam logic [TOK_W-1:0] TOK_ZERO     = 5'd0;
	localparam logic [TOK_W-1:0] TOK_TWENTY   = 5'd20;
	localparam logic [TOK_W-1:0] TOK_HUNDRED  = 5'd28;
	localparam logic [TOK_W-1:0] TOK_THOUSAND = 5'd29;
	localparam logic [TOK_W-1:0] TOK_MILLION  = 5'd30;
	localparam logic [TOK_W-1:0] TOK_BILLION  = 5'd31;

	localparam logic [1:0] GP_UNITS     = 2'd0;
	localparam logic [1:0] GP_THOUSANDS = 2'd1;
	localparam logic [1:0] GP_MILLIONS  = 2'd2;
	localparam logic [1:0] GP_BILLIONS  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		PH_HUND_DIGIT,
		PH_HUNDRED,
		PH_REST,
		PH_UNIT,
		PH_SCALE
	} phase_t;

endpackage

>>> rtl/core/number_to_word_tokens.sv
// ----------------------------------------------------------------------------
// number_to_word_tokens
// Spells a 31-bit unsigned integer as a run of English word tokens.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with value. One beat is one number.
// Output channel: out_valid/out_ready with word_token and last_word. Each
// number gives 1 to 16 beats in reading order; last_word marks the final one.
// The number first runs through a shift-add-3 binary to BCD converter, one
// input bit per cycle. A sequencer then walks the four groups (billions
// down to units), five steps per group, one step a cycle unless a token
// waits on a stalled output, loading a token into the output register on
// steps that produce one, and stops on the final token: at most 19 steps.
// in_ready is high again once the final token sits in the output register.
// The output register holds a token while out_ready is low; the sequencer
// waits on it and resumes when the beat is taken.
// Reset (arst_n low) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module number_to_word_tokens (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [nwt_pkg::BIN_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [nwt_pkg::TOK_W-1:0]  word_token,
	output logic                       last_word
);

	nwt_pkg::state_t                 state_q, state_d;
	nwt_pkg::phase_t                 phase_q, phase_nx;
	logic [1:0]                      gp_q;
	logic [nwt_pkg::CNT_W-1:0]       cnt_q;
	logic [nwt_pkg::BIN_W-1:0]       bin_q;
	logic [nwt_pkg::BCD_W-1:0]       bcd_q, bcd_adj;
	logic                            zero_q;
	logic                            out_valid_q;
	logic [nwt_pkg::TOK_W-1:0]       tok_q;
	logic                            last_q;

	logic [3:0]                      dh, dt, du;
	logic                            lower_nz, h_nz, r_nz, r_big, more;
	logic [nwt_pkg::TOK_W-1:0]       r_small, scale_tok;
	logic                            tok_emit, tok_last, slot_free, step, load_out, done;
	logic [nwt_pkg::TOK_W-1:0]       tok;

	// Add 3 to every BCD digit of five or more before the shift.
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < nwt_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	// Select the digits of the current group.
	always_comb begin
		case (gp_q)
			nwt_pkg::GP_BILLIONS: begin
				dh = 4'd0; dt = 4'd0; du = bcd_q[39:36];
				lower_nz  = |bcd_q[35:0];
				scale_tok = nwt_pkg::TOK_BILLION;
			end
			nwt_pkg::GP_MILLIONS: begin
				dh = bcd_q[35:32]; dt = bcd_q[31:28]; du = bcd_q[27:24];
				lower_nz  = |bcd_q[23:0];
				scale_tok = nwt_pkg::TOK_MILLION;
			end
			nwt_pkg::GP_THOUSANDS: begin
				dh = bcd_q[23:20]; dt = bcd_q[19:16]; du = bcd_q[15:12];
				lower_nz  = |bcd_q[11:0];
				scale_tok = nwt_pkg::TOK_THOUSAND;
			end
			default: begin
				dh = bcd_q[11:8]; dt = bcd_q[7:4]; du = bcd_q[3:0];
				lower_nz  = 1'b0;
				scale_tok = nwt_pkg::TOK_ZERO;
			end
		endcase
	end

	assign h_nz    = (dh != 4'd0);
	assign r_nz    = (dt != 4'd0) || (du != 4'd0);
	assign r_big   = (dt > 4'd2) || ((dt == 4'd2) && (du != 4'd0));
	assign r_small = 5'({dt[1:0], 3'b000}) + 5'({dt[1:0], 1'b0}) + 5'(du);

	// Token and lookahead for the current step.
	always_comb begin
		tok_emit = 1'b0;
		tok      = nwt_pkg::TOK_ZERO;
		more     = 1'b0;
		phase_nx = nwt_pkg::PH_HUND_DIGIT;
		if (zero_q) begin
			tok_emit = 1'b1;
		end else begin
			case (phase_q)
				nwt_pkg::PH_HUND_DIGIT: begin
					tok_emit = h_nz;
					tok      = 5'(dh);
					more     = 1'b1;
					phase_nx = nwt_pkg::PH_HUNDRED;
				end
				nwt_pkg::PH_HUNDRED: begin
					tok_emit = h_nz;
					tok      = nwt_pkg::TOK_HUNDRED;
					more     = r_nz || (gp_q != nwt_pkg::GP_UNITS);
					phase_nx = nwt_pkg::PH_REST;
				end
				nwt_pkg::PH_REST: begin
					tok_emit = r_nz;
					tok      = r_big ? (nwt_pkg::TOK_TWENTY + 5'(dt) - 5'd2) : r_small;
					more     = (r_big && (du != 4'd0)) || (gp_q != nwt_pkg::GP_UNITS);
					phase_nx = nwt_pkg::PH_UNIT;
				end
				nwt_pkg::PH_UNIT: begin
					tok_emit = r_big && (du != 4'd0);
					tok      = 5'(du);
					more     = (gp_q != nwt_pkg::GP_UNITS);
					phase_nx = nwt_pkg::PH_SCALE;
				end
				nwt_pkg::PH_SCALE: begin
					tok_emit = (gp_q != nwt_pkg::GP_UNITS) && (h_nz || r_nz);
					tok      = scale_tok;
					phase_nx = nwt_pkg::PH_HUND_DIGIT;
				end
				default: begin
					phase_nx = nwt_pkg::PH_HUND_DIGIT;
				end
			endcase
		end
	end

	assign tok_last = zero_q || (!more && !lower_nz);

	// Control outputs.
	always_comb begin
		in_ready  = (state_q == nwt_pkg::ST_IDLE);
		slot_free = !out_valid_q || out_ready;
		step      = (state_q == nwt_pkg::ST_EMIT) && (!tok_emit || slot_free);
		load_out  = step && tok_emit;
		done      = step && ((tok_emit && tok_last) ||
			((gp_q == nwt_pkg::GP_UNITS) && (phase_q == nwt_pkg::PH_SCALE)));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			nwt_pkg::ST_IDLE: begin
				if (in_valid) state_d = nwt_pkg::ST_CONVERT;
			end
			nwt_pkg::ST_CONVERT: begin
				if (cnt_q == nwt_pkg::CNT_LAST) state_d = nwt_pkg::ST_EMIT;
			end
			nwt_pkg::ST_EMIT: begin
				if (done) state_d = nwt_pkg::ST_IDLE;
			end
			default: state_d = nwt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nwt_pkg::ST_IDLE;
			phase_q     <= nwt_pkg::PH_HUND_DIGIT;
			gp_q        <= nwt_pkg::GP_UNITS;
			cnt_q       <= '0;
			bcd_q       <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				zero_q  <= (value == '0);
				cnt_q   <= '0;
				bcd_q   <= '0;
				gp_q    <= nwt_pkg::GP_BILLIONS;
				phase_q <= nwt_pkg::PH_HUND_DIGIT;
			end
			if (state_q == nwt_pkg::ST_CONVERT) begin
				cnt_q <= cnt_q + 1'b1;
				bcd_q <= {bcd_adj[nwt_pkg::BCD_W-2:0], bin_q[nwt_pkg::BIN_W-1]};
			end
			if (step) begin
				phase_q <= phase_nx;
				if (phase_q == nwt_pkg::PH_SCALE) gp_q <= gp_q - 2'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: shift the binary value, hold the output beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bin_q <= value;
		end else if (state_q == nwt_pkg::ST_CONVERT) begin
			bin_q <= {bin_q[nwt_pkg::BIN_W-2:0], 1'b0};
		end
		if (load_out) begin
			tok_q  <= tok;
			last_q <= tok_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign word_token = tok_q;
	assign last_word  = last_q;

endmodule

>>> rtl/core/nwt_checker.sv
// ----------------------------------------------------------------------------
// nwt_checker
// Port-level checks for number_to_word_tokens, bound to the top level.
// ----------------------------------------------------------------------------
module nwt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [nwt_pkg::BIN_W-1:0]  value,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [nwt_pkg::TOK_W-1:0]  word_token,
	input logic                       last_word
);

	// Hold a stalled output beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_token) && $stable(last_word))
		else $error("stalled output beat changed");

	// Drop ready after an accepted number; checked at the first and the last cycle of the conversion.
	a_busy_convert: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##30 !in_ready)
		else $error("input ready during conversion");

	// A non-final token means the spelling is still in progress.
	a_busy_midrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_word |-> !in_ready)
		else $error("input ready before final token");

	// Nothing new appears at the output right after an accept.
	a_no_early_token: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("token before conversion finished");

endmodule

bind number_to_word_tokens nwt_checker u_nwt_checker (.*);
